// ===== rtl/two_link_inverse_kinematics_core_assert.svh =====
// assertion macros for the two-link inverse kinematics core
`ifndef TWO_LINK_INVERSE_KINEMATICS_CORE_ASSERT_SVH
`define TWO_LINK_INVERSE_KINEMATICS_CORE_ASSERT_SVH
`ifndef SYNTH
`define TLIK_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("tlik assertion failed");
`define TLIK_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("tlik assertion failed");
`else
`define TLIK_ASSERT(lbl, clk, rstn, prop)
`define TLIK_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/tlik_pkg.sv =====
package tlik_pkg;

    localparam int XW     = 18;   // target coordinate
    localparam int LW     = 17;   // link length
    localparam int HW     = 17;   // hip angle
    localparam int KW     = 16;   // knee angle
    localparam int QW     = 31;   // cosine quotient bits
    localparam int NW     = 36;   // |r^2 - l1^2 - l2^2|
    localparam int DW     = 35;   // 2 l1 l2
    localparam int RW     = 37;   // divider remainder
    localparam int CABSW  = 31;   // |cos| in q30
    localparam int CSW    = 32;   // signed cos in q30
    localparam int RADW   = 62;   // sqrt radicand, even width
    localparam int ROOTW  = 31;   // sqrt root
    localparam int SREMW  = 34;   // sqrt remainder
    localparam int CW     = 52;   // cordic vector
    localparam int ZW     = 33;   // cordic angle, pi/2^31 units

    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic [LW-1:0] L1_RST = 17'd13107;
    localparam logic [LW-1:0] L2_RST = 17'd16384;

    localparam logic [QW-1:0] ONE_Q30 = 31'h4000_0000;
    localparam logic signed [ZW-1:0] HALF_PI = 33'sh0_4000_0000;

    typedef enum logic {
        REG_UPPER = 1'b0,
        REG_LOWER = 1'b1
    } t_reg_idx;

    // side data traveling with the divider
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic [LW-1:0]        l1;
        logic [LW-1:0]        l2;
        logic                 reach;
        logic                 neg;
        logic                 dz;
    } t_dside;

    // side data traveling with the square root
    typedef struct packed {
        logic signed [XW-1:0]  x;
        logic signed [XW-1:0]  y;
        logic [LW-1:0]         l1;
        logic [LW-1:0]         l2;
        logic                  reach;
        logic signed [CSW-1:0] c;
    } t_sside;

    // atan(2^-i) in units of pi/2^31
    function automatic logic signed [ZW-1:0] f_atan(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = 33'sd536870912;
            1:  v = 33'sd316933406;
            2:  v = 33'sd167458907;
            3:  v = 33'sd85004756;
            4:  v = 33'sd42667331;
            5:  v = 33'sd21354465;
            6:  v = 33'sd10679838;
            7:  v = 33'sd5340245;
            8:  v = 33'sd2670163;
            9:  v = 33'sd1335087;
            10: v = 33'sd667544;
            11: v = 33'sd333772;
            12: v = 33'sd166886;
            13: v = 33'sd83443;
            14: v = 33'sd41722;
            15: v = 33'sd20861;
            16: v = 33'sd10430;
            17: v = 33'sd5215;
            18: v = 33'sd2608;
            19: v = 33'sd1304;
            20: v = 33'sd652;
            21: v = 33'sd326;
            22: v = 33'sd163;
            23: v = 33'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/tlik_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module tlik_div
    import tlik_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  t_dside        i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output t_dside        o_side
);

    logic [RW-1:0] r_rem  [0:QW-1];
    logic [QW-1:0] r_quo  [0:QW-1];
    logic [DW-1:0] r_den  [0:QW-1];
    t_dside        r_side [0:QW-1];
    logic          r_vld  [0:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [RW-1:0] w_t;
        logic [DW-1:0] w_den;
        logic [QW-1:0] w_quo;
        t_dside        w_side;
        logic          w_v;
        logic          n_bit;
        logic [RW-1:0] n_rem;

        if (k == 0) begin : g_in
            assign w_t    = {1'b0, i_num};
            assign w_den  = i_den;
            assign w_quo  = '0;
            assign w_side = i_side;
            assign w_v    = i_valid;
        end else begin : g_mid
            assign w_t    = {r_rem[k-1][RW-2:0], 1'b0};
            assign w_den  = r_den[k-1];
            assign w_quo  = r_quo[k-1];
            assign w_side = r_side[k-1];
            assign w_v    = r_vld[k-1];
        end

        always_comb begin
            n_bit = (w_t >= {2'b00, w_den});
            n_rem = n_bit ? (w_t - {2'b00, w_den}) : w_t;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_quo[k]  <= {w_quo[QW-2:0], n_bit};
                r_den[k]  <= w_den;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ===== rtl/tlik_isqrt.sv =====
// pipelined digit-by-digit integer square root, one root bit per stage
module tlik_isqrt
    import tlik_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [RADW-1:0]  i_rad,
    input  t_sside           i_side,
    output logic             o_valid,
    output logic [ROOTW-1:0] o_root,
    output t_sside           o_side
);

    logic [SREMW-1:0] r_rem  [0:ROOTW-1];
    logic [ROOTW-1:0] r_root [0:ROOTW-1];
    logic [RADW-1:0]  r_rad  [0:ROOTW-1];
    t_sside           r_side [0:ROOTW-1];
    logic             r_vld  [0:ROOTW-1];

    for (genvar k = 0; k < ROOTW; k++) begin : g_stage
        localparam int P = ROOTW - 1 - k;
        logic [SREMW-1:0] w_rem;
        logic [ROOTW-1:0] w_root;
        logic [RADW-1:0]  w_rad;
        t_sside           w_side;
        logic             w_v;
        logic [SREMW+1:0] n_t;
        logic [SREMW+1:0] n_trial;
        logic [SREMW+1:0] n_diff;
        logic             n_bit;

        if (k == 0) begin : g_in
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_rad  = i_rad;
            assign w_side = i_side;
            assign w_v    = i_valid;
        end else begin : g_mid
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_rad  = r_rad[k-1];
            assign w_side = r_side[k-1];
            assign w_v    = r_vld[k-1];
        end

        always_comb begin
            n_t     = {w_rem, w_rad[2*P+1 -: 2]};
            n_trial = {3'b000, w_root, 2'b01};
            n_diff  = n_t - n_trial;
            n_bit   = (n_t >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_bit ? n_diff[SREMW-1:0] : n_t[SREMW-1:0];
                r_root[k] <= {w_root[ROOTW-2:0], n_bit};
                r_rad[k]  <= w_rad;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[ROOTW-1];
    assign o_root  = r_root[ROOTW-1];
    assign o_side  = r_side[ROOTW-1];

endmodule

// ===== rtl/tlik_cordic.sv =====
// pipelined vectoring cordic, atan2 in units of pi/2^31
module tlik_cordic
    import tlik_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    output logic                 o_valid,
    output logic signed [ZW-1:0] o_angle
);

    logic signed [CW-1:0] r_x    [0:STAGES];
    logic signed [CW-1:0] r_y    [0:STAGES];
    logic signed [ZW-1:0] r_z    [0:STAGES];
    logic                 r_zero [0:STAGES];
    logic                 r_vld  [0:STAGES];

    logic signed [CW-1:0] n_x0;
    logic signed [CW-1:0] n_y0;
    logic signed [ZW-1:0] n_z0;

    // quadrant fold into the right half plane
    always_comb begin
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x0 = i_y;
                n_y0 = -i_x;
                n_z0 = HALF_PI;
            end else begin
                n_x0 = -i_y;
                n_y0 = i_x;
                n_z0 = -HALF_PI;
            end
        end else begin
            n_x0 = i_x;
            n_y0 = i_y;
            n_z0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_zero[0] <= (i_x == 0) && (i_y == 0);
        end
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_iter
        logic signed [CW-1:0] w_xs;
        logic signed [CW-1:0] w_ys;

        assign w_xs = r_x[k] >>> k;
        assign w_ys = r_y[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[k] > 0) begin
                    r_x[k+1] <= r_x[k] + w_ys;
                    r_y[k+1] <= r_y[k] - w_xs;
                    r_z[k+1] <= r_z[k] + f_atan(k);
                end else begin
                    r_x[k+1] <= r_x[k] - w_ys;
                    r_y[k+1] <= r_y[k] + w_xs;
                    r_z[k+1] <= r_z[k] - f_atan(k);
                end
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    assign o_valid = r_vld[STAGES];
    assign o_angle = r_zero[STAGES] ? '0 : r_z[STAGES];

endmodule

// ===== rtl/two_link_inverse_kinematics_core.sv =====
// Two-link planar inverse kinematics. A target (x, y) in Q2.16 metres enters on the
// input channel and one result leaves on the output channel: the hip angle, the knee
// angle (both in units of pi/32768) and a reach flag; a target outside the annulus
// |l1-l2| <= r <= l1+l2 gives zero angles and reachable low. Link lengths sit in two
// APB registers (upper link at 0x0, lower link at 0x4, 17 bits, 1/65536 m). The core is
// a fully pipelined datapath that takes one target every cycle while the skid entry is
// free; each target passes through the 31-stage cosine divider, the 31-stage square root
// and the three parallel cordic pipelines. A two-entry output buffer keeps the input
// open while one result waits.
`include "two_link_inverse_kinematics_core_assert.svh"

module two_link_inverse_kinematics_core
    import tlik_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // target channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [XW-1:0] i_x_pos,
    input  logic signed [XW-1:0] i_y_pos,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [HW-1:0] o_hip_angle,
    output logic [KW-1:0]        o_knee_angle,
    output logic                 o_reachable,
    // register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // ---------------- link length registers ----------------
    logic [LW-1:0] r_l1;
    logic [LW-1:0] r_l2;
    t_reg_idx      w_idx;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1 <= L1_RST;
            r_l2 <= L2_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (w_idx)
                REG_UPPER: r_l1 <= pwdata[LW-1:0];
                REG_LOWER: r_l2 <= pwdata[LW-1:0];
                default:   r_l1 <= r_l1;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_UPPER: prdata = {{(32-LW){1'b0}}, r_l1};
            REG_LOWER: prdata = {{(32-LW){1'b0}}, r_l2};
            default:   prdata = '0;
        endcase
    end

    // global advance: the pipeline moves whenever the skid entry is free
    logic w_en;
    logic r_hv;
    logic r_sv;

    assign w_en       = !r_sv;
    assign o_in_ready = w_en;

    // ---------------- stage 1: squares and link product ----------------
    logic                   r_v1;
    logic signed [XW-1:0]   r_x1, r_y1;
    logic [LW-1:0]          r_l1_1, r_l2_1;
    logic [2*XW-2:0]        r_xx1, r_yy1;
    logic [2*LW-1:0]        r_l11, r_l22, r_l12;
    logic signed [2*XW-1:0] n_xx, n_yy;

    assign n_xx = i_x_pos * i_x_pos;
    assign n_yy = i_y_pos * i_y_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x1   <= i_x_pos;
            r_y1   <= i_y_pos;
            r_l1_1 <= r_l1;
            r_l2_1 <= r_l2;
            r_xx1  <= n_xx[2*XW-2:0];
            r_yy1  <= n_yy[2*XW-2:0];
            r_l11  <= r_l1 * r_l1;
            r_l22  <= r_l2 * r_l2;
            r_l12  <= r_l1 * r_l2;
        end
    end

    // ---------------- stage 2: r^2, l1^2 + l2^2, 2 l1 l2 ----------------
    logic                 r_v2;
    logic signed [XW-1:0] r_x2, r_y2;
    logic [LW-1:0]        r_l1_2, r_l2_2;
    logic [NW-1:0]        r_r2;
    logic [DW-1:0]        r_sm2;
    logic [DW-1:0]        r_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x2   <= r_x1;
            r_y2   <= r_y1;
            r_l1_2 <= r_l1_1;
            r_l2_2 <= r_l2_1;
            r_r2   <= {1'b0, r_xx1} + {1'b0, r_yy1};
            r_sm2  <= {1'b0, r_l11} + {1'b0, r_l22};
            r_d2   <= {r_l12, 1'b0};
        end
    end

    // ---------------- stage 3: reach test and |numerator| ----------------
    logic          r_v3;
    logic [NW-1:0] r_nabs3;
    logic [DW-1:0] r_d3;
    t_dside        r_ds3;
    logic [NW-1:0] n_ss;
    logic [NW-1:0] n_dd;
    logic          n_ge;
    logic          n_reach;

    always_comb begin
        n_ss    = {1'b0, r_sm2} + {1'b0, r_d2};   // (l1 + l2)^2
        n_dd    = {1'b0, r_sm2} - {1'b0, r_d2};   // (l1 - l2)^2
        n_ge    = (r_r2 >= {1'b0, r_sm2});
        n_reach = (r_r2 <= n_ss) && (r_r2 >= n_dd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nabs3     <= n_ge ? (r_r2 - {1'b0, r_sm2}) : ({1'b0, r_sm2} - r_r2);
            r_d3        <= r_d2;
            r_ds3.x     <= r_x2;
            r_ds3.y     <= r_y2;
            r_ds3.l1    <= r_l1_2;
            r_ds3.l2    <= r_l2_2;
            r_ds3.reach <= n_reach;
            r_ds3.neg   <= !n_ge;
            r_ds3.dz    <= (r_d2 == '0);
        end
    end

    // ---------------- cosine quotient ----------------
    logic          w_dv;
    logic [QW-1:0] w_quo;
    t_dside        w_ds;

    tlik_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v3),
        .i_num   (r_nabs3),
        .i_den   (r_d3),
        .i_side  (r_ds3),
        .o_valid (w_dv),
        .o_quo   (w_quo),
        .o_side  (w_ds)
    );

    // ---------------- stage 4: clamp and sign of cos q2 ----------------
    logic             r_v4;
    logic [CABSW-1:0] r_cabs4;
    t_sside           r_ss4;
    logic [QW-1:0]    n_qc;
    logic [CABSW-1:0] n_cabs;
    logic signed [CSW-1:0] n_c;

    always_comb begin
        n_qc   = (w_quo > ONE_Q30) ? ONE_Q30 : w_quo;
        // zero-length link: cos q2 taken as one
        n_cabs = w_ds.dz ? ONE_Q30 : n_qc;
        n_c    = (w_ds.neg && !w_ds.dz) ? -$signed({1'b0, n_cabs}) : $signed({1'b0, n_cabs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= w_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cabs4     <= n_cabs;
            r_ss4.x     <= w_ds.x;
            r_ss4.y     <= w_ds.y;
            r_ss4.l1    <= w_ds.l1;
            r_ss4.l2    <= w_ds.l2;
            r_ss4.reach <= w_ds.reach;
            r_ss4.c     <= n_c;
        end
    end

    // ---------------- stage 5: cos^2 ----------------
    logic             r_v5;
    logic [RADW-2:0]  r_cc5;
    t_sside           r_ss5;
    logic [2*CABSW-1:0] n_cc;

    assign n_cc = r_cabs4 * r_cabs4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cc5 <= n_cc[RADW-2:0];
            r_ss5 <= r_ss4;
        end
    end

    // ---------------- stage 6: 2^60 - cos^2 ----------------
    logic            r_v6;
    logic [RADW-1:0] r_rad6;
    t_sside          r_ss6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (w_en) begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rad6 <= {1'b0, {1'b1, {(RADW-2){1'b0}}} - r_cc5};
            r_ss6  <= r_ss5;
        end
    end

    // ---------------- sin q2 ----------------
    logic             w_sv;
    logic [ROOTW-1:0] w_s;
    t_sside           w_ss;

    tlik_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v6),
        .i_rad   (r_rad6),
        .i_side  (r_ss6),
        .o_valid (w_sv),
        .o_root  (w_s),
        .o_side  (w_ss)
    );

    // ---------------- stage 7: l2 sin, l2 cos ----------------
    logic                          r_v7;
    logic [LW+ROOTW-1:0]           r_l2s7;
    logic signed [LW+CSW:0]        r_l2c7;
    logic [ROOTW-1:0]              r_s7;
    t_sside                        r_ss7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else if (w_en) begin
            r_v7 <= w_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l2s7 <= w_ss.l2 * w_s;
            r_l2c7 <= $signed({1'b0, w_ss.l2}) * w_ss.c;
            r_s7   <= w_s;
            r_ss7  <= w_ss;
        end
    end

    // ---------------- stage 8: cordic input vectors ----------------
    logic                 r_v8;
    logic                 r_rch8;
    logic signed [CW-1:0] r_kx8, r_ky8;
    logic signed [CW-1:0] r_a1x8, r_a1y8;
    logic signed [CW-1:0] r_a2x8, r_a2y8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
        end else if (w_en) begin
            r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rch8 <= r_ss7.reach;
            r_kx8  <= {{(CW-CSW){r_ss7.c[CSW-1]}}, r_ss7.c};
            r_ky8  <= {{(CW-ROOTW){1'b0}}, r_s7};
            r_a1x8 <= {{(CW-XW-24){r_ss7.x[XW-1]}}, r_ss7.x, 24'b0};
            r_a1y8 <= {{(CW-XW-24){r_ss7.y[XW-1]}}, r_ss7.y, 24'b0};
            // l1 * 2^30 + l2 * cos
            r_a2x8 <= $signed({{(CW-LW-30){1'b0}}, r_ss7.l1, 30'b0})
                    + $signed({{(CW-LW-CSW-1){r_l2c7[LW+CSW]}}, r_l2c7});
            r_a2y8 <= {{(CW-LW-ROOTW){1'b0}}, r_l2s7};
        end
    end

    // ---------------- angle cordics ----------------
    logic                 w_kv;
    logic signed [ZW-1:0] w_zk, w_za1, w_za2;

    tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_knee (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v8),
        .i_x     (r_kx8),
        .i_y     (r_ky8),
        .o_valid (w_kv),
        .o_angle (w_zk)
    );

    tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_tgt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v8),
        .i_x     (r_a1x8),
        .i_y     (r_a1y8),
        .o_valid (),
        .o_angle (w_za1)
    );

    tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_leg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v8),
        .i_x     (r_a2x8),
        .i_y     (r_a2y8),
        .o_valid (),
        .o_angle (w_za2)
    );

    // reach flag delayed alongside the cordics
    logic r_rch_d [0:CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rch_d[0] <= r_rch8;
            for (int i = 1; i <= CORDIC_STAGES; i++) begin
                r_rch_d[i] <= r_rch_d[i-1];
            end
        end
    end

    // ---------------- stage 9: rounding offset and hip difference ----------------
    logic                 r_v9;
    logic                 r_rch9;
    logic signed [ZW:0]   r_kr9;
    logic signed [ZW:0]   r_hd9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v9 <= 1'b0;
        end else if (w_en) begin
            r_v9 <= w_kv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rch9 <= r_rch_d[CORDIC_STAGES];
            r_kr9  <= {w_zk[ZW-1], w_zk} + (ZW+1)'(32768);
            r_hd9  <= {w_za1[ZW-1], w_za1} - {w_za2[ZW-1], w_za2};
        end
    end

    // final scaling, saturation and unreachable zeroing
    logic signed [ZW-16:0]  n_kq;
    logic signed [ZW+1:0]   n_hr;
    logic signed [ZW-15:0]  n_hq;
    logic [KW-1:0]          n_knee;
    logic signed [HW-1:0]   n_hip;
    logic                   n_push;

    always_comb begin
        n_kq = r_kr9[ZW:16];
        n_hr = {r_hd9[ZW], r_hd9} + (ZW+2)'(32768);
        n_hq = n_hr[ZW+1:16];
        if (n_kq < 0) begin
            n_knee = '0;
        end else if (n_kq > 32768) begin
            n_knee = 16'd32768;
        end else begin
            n_knee = n_kq[KW-1:0];
        end
        if (n_hq < -65536) begin
            n_hip = 17'sh1_0000;
        end else if (n_hq > 65535) begin
            n_hip = 17'sh0_FFFF;
        end else begin
            n_hip = n_hq[HW-1:0];
        end
        if (!r_rch9) begin
            n_knee = '0;
            n_hip  = '0;
        end
        n_push = r_v9 && w_en;
    end

    // ---------------- output register with skid entry ----------------
    logic signed [HW-1:0] r_hip_h, r_hip_s;
    logic [KW-1:0]        r_knee_h, r_knee_s;
    logic                 r_rch_h, r_rch_s;
    logic                 w_pop;

    assign w_pop = r_hv && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_hv || w_pop) begin
            if (r_sv) begin
                r_hv <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_hv <= n_push;
            end
        end else if (n_push) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_hv || w_pop) begin
            if (r_sv) begin
                r_hip_h  <= r_hip_s;
                r_knee_h <= r_knee_s;
                r_rch_h  <= r_rch_s;
            end else begin
                r_hip_h  <= n_hip;
                r_knee_h <= n_knee;
                r_rch_h  <= r_rch9;
            end
        end else if (n_push) begin
            r_hip_s  <= n_hip;
            r_knee_s <= n_knee;
            r_rch_s  <= r_rch9;
        end
    end

    assign o_out_valid  = r_hv;
    assign o_hip_angle  = r_hip_h;
    assign o_knee_angle = r_knee_h;
    assign o_reachable  = r_rch_h;

    // skid entry only fills behind a held result
    `TLIK_ASSERT(a_skid_needs_head, i_clk, i_rst_n, r_sv |-> r_hv)
    // unreachable targets report zero angles
    `TLIK_ASSERT(a_unreach_zero, i_clk, i_rst_n, (o_out_valid && !o_reachable) |-> ((o_hip_angle == '0) && (o_knee_angle == '0)))
    // knee stays within zero to pi
    `TLIK_ASSERT(a_knee_range, i_clk, i_rst_n, o_out_valid |-> (o_knee_angle <= 16'd32768))

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import tlik_pkg::*;

    // one target and one expected solution
    typedef struct {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
    } target_t;

    typedef struct {
        logic signed [HW-1:0] hip;
        logic [KW-1:0]        knee;
        logic                 reach;
    } joint_sol_t;

    localparam int  MAX_CYCLES    = 600000;
    localparam int  DRAIN_CYCLES  = 120;
    localparam int  ITEMS_PER_SET = 170;
    localparam longint ONE_Q30_L  = 64'sd1 << 30;
    localparam longint HALF_PI_L  = 64'sd1 << 30;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic signed [XW-1:0] i_x_pos;
    logic signed [XW-1:0] i_y_pos;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic signed [HW-1:0] o_hip_angle;
    logic [KW-1:0]        o_knee_angle;
    logic                 o_reachable;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    two_link_inverse_kinematics_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_x_pos      (i_x_pos),
        .i_y_pos      (i_y_pos),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hip_angle  (o_hip_angle),
        .o_knee_angle (o_knee_angle),
        .o_reachable  (o_reachable),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // shadow copy of the link length registers
    longint upper_len;
    longint lower_len;

    target_t    pending_targets[$];
    joint_sol_t expected_sols[$];
    int         mismatch_cnt;
    int         cycle_cnt;
    logic       tgt_xfer;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // append a target to the driver queue
    function automatic void add_target(target_t tg);
        pending_targets.insert(pending_targets.size(), tg);
    endfunction

    // integer square root, floor
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // vectoring cordic, angle in units of pi/2^31
    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint t;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = y; y = -x; x = t; z = HALF_PI_L;
            end else begin
                t = -y; y = x; x = t; z = -HALF_PI_L;
            end
        end
        for (int i = 0; i < CORDIC_STAGES_DEF && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + longint'(f_atan(i));
            end else begin
                x = x - ys; y = y + xs; z = z - longint'(f_atan(i));
            end
        end
        return z;
    endfunction

    // joint angles for a target under the current link lengths
    function automatic joint_sol_t solve_joints(target_t tg);
        joint_sol_t      sol;
        longint          x, y, r2, dif, sum, n, d, c, s, hip, knee, a1, a2;
        longint unsigned rem, ud, q;
        x   = tg.x;
        y   = tg.y;
        r2  = x * x + y * y;
        dif = upper_len - lower_len;
        sum = upper_len + lower_len;
        sol.hip   = '0;
        sol.knee  = '0;
        sol.reach = 1'b0;
        if (r2 > sum * sum || r2 < dif * dif) return sol;
        n = r2 - upper_len * upper_len - lower_len * lower_len;
        d = 2 * upper_len * lower_len;
        // degenerate link gives a straight knee
        if (d == 0) begin
            c = ONE_Q30_L;
        end else begin
            rem = (n < 0) ? -n : n;
            ud  = d;
            q   = 0;
            if (rem >= ud) begin
                q = 1; rem = rem - ud;
            end
            for (int k = 0; k < 30; k++) begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= ud) begin
                    rem = rem - ud; q = q | 1;
                end
            end
            if (q > ONE_Q30_L) q = ONE_Q30_L;
            c = (n < 0) ? -longint'(q) : longint'(q);
        end
        s = int_sqrt((64'd1 << 60) - longint'(c * c));
        knee = (vector_angle(s, c) + 32768) >>> 16;
        if (knee < 0) knee = 0;
        if (knee > 32768) knee = 32768;
        a1  = vector_angle(y * (64'sd1 << 24), x * (64'sd1 << 24));
        a2  = vector_angle(lower_len * s, upper_len * ONE_Q30_L + lower_len * c);
        hip = (a1 - a2 + 32768) >>> 16;
        if (hip < -65536) hip = -65536;
        if (hip > 65535) hip = 65535;
        sol.hip   = hip[HW-1:0];
        sol.knee  = knee[KW-1:0];
        sol.reach = 1'b1;
        return sol;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > 131071) return 131071;
        if (v < -131072) return -131072;
        return v;
    endfunction

    function automatic target_t make_target(longint x, longint y);
        target_t tg;
        tg.x = XW'(clamp_coord(x));
        tg.y = XW'(clamp_coord(y));
        return tg;
    endfunction

    // random target inside the annulus, falls back to a full-range one
    function automatic target_t reachable_target();
        target_t    tg;
        joint_sol_t sol;
        longint     m;
        m = upper_len + lower_len;
        if (m > 131071) m = 131071;
        for (int tries = 0; tries < 40; tries++) begin
            tg.x = XW'(longint'($urandom_range(0, int'(2 * m))) - m);
            tg.y = XW'(longint'($urandom_range(0, int'(2 * m))) - m);
            sol  = solve_joints(tg);
            if (sol.reach) return tg;
        end
        tg.x = XW'($urandom);
        tg.y = XW'($urandom);
        return tg;
    endfunction

    // corners of the workspace and of the coordinate range
    task automatic push_corner_targets();
        longint sum;
        longint dif;
        sum = upper_len + lower_len;
        dif = upper_len - lower_len;
        if (dif < 0) dif = -dif;
        add_target(make_target(131071, 131071));
        add_target(make_target(-131072, -131072));
        add_target(make_target(131071, -131072));
        add_target(make_target(0, 0));
        add_target(make_target(sum, 0));
        add_target(make_target(0, -sum));
        add_target(make_target(-sum, 0));
        add_target(make_target(sum + 1, 0));
        add_target(make_target(dif, 0));
        add_target(make_target(0, dif));
        add_target(make_target(-dif, 0));
        add_target(make_target(dif - 1, 0));
    endtask

    // two-phase register write, setup then access
    task automatic write_link(t_reg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == REG_UPPER) upper_len = longint'(value & 32'h1FFFF);
        else                  lower_len = longint'(value & 32'h1FFFF);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_targets.size() != 0 || i_in_valid || expected_sols.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // stimulus sequence: link settings, each with corners then random targets
    initial begin
        longint  upper_set[8];
        longint  lower_set[8];
        target_t rnd_tg;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_x_pos     = '0;
        i_y_pos     = '0;
        i_out_ready = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        upper_len   = L1_RST;
        lower_len   = L2_RST;
        upper_set   = '{13107, 65536, 0, 30000, 0, 1, 50000, 65536};
        lower_set   = '{16384, 65536, 40000, 0, 0, 65536, 20000, 1};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int ph = 0; ph < 8; ph++) begin
            // reset values hold for the first setting
            if (ph != 0) begin
                write_link(REG_UPPER, 32'(upper_set[ph]));
                write_link(REG_LOWER, 32'(lower_set[ph]));
            end
            push_corner_targets();
            for (int i = 0; i < ITEMS_PER_SET; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    // full coordinate range, mostly out of reach
                    rnd_tg.x = XW'($urandom);
                    rnd_tg.y = XW'($urandom);
                    add_target(rnd_tg);
                end else begin
                    add_target(reachable_target());
                end
            end
            wait_idle();
        end
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // target driver: bursts of transfers separated by random gaps
    int burst_left;
    int gap_left;
    always @(negedge i_clk) begin
        target_t tg;
        if (!i_rst_n) begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= 0;
        end else if (!(i_in_valid && !tgt_xfer)) begin
            if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end else if (pending_targets.size() != 0) begin
                tg = pending_targets.pop_front();
                i_x_pos    <= tg.x;
                i_y_pos    <= tg.y;
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    // some bursts run straight into the next one
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver stall pattern, rotates through four ready modes
    always @(negedge i_clk) begin
        case ((cycle_cnt / 400) % 4)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 1) == 1);
            2: i_out_ready <= ((cycle_cnt % 7) > 2);
            default: i_out_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // monitor: predict on target transfer, check on result transfer
    always @(posedge i_clk) begin
        target_t    tg;
        joint_sol_t exp_sol;
        int         errs;
        errs = 0;
        cycle_cnt <= cycle_cnt + 1;
        tgt_xfer  <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            tg.x = i_x_pos;
            tg.y = i_y_pos;
            expected_sols.insert(expected_sols.size(), solve_joints(tg));
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_sols.size() == 0) begin
                $error("result transfer with no target outstanding");
                errs = errs + 1;
            end else begin
                exp_sol = expected_sols.pop_front();
                if (o_hip_angle !== exp_sol.hip) begin
                    $error("hip_angle expected %0d actual %0d", exp_sol.hip, o_hip_angle);
                    errs = errs + 1;
                end
                if (o_knee_angle !== exp_sol.knee) begin
                    $error("knee_angle expected %0d actual %0d", exp_sol.knee, o_knee_angle);
                    errs = errs + 1;
                end
                if (o_reachable !== exp_sol.reach) begin
                    $error("reachable expected %0d actual %0d", exp_sol.reach, o_reachable);
                    errs = errs + 1;
                end
            end
        end
        if (errs != 0) begin
            mismatch_cnt <= mismatch_cnt + errs;
        end
    end

    initial begin
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        tgt_xfer     = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycle_cnt >= MAX_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tlik_pkg.sv
rtl/tlik_div.sv
rtl/tlik_isqrt.sv
rtl/tlik_cordic.sv
rtl/two_link_inverse_kinematics_core.sv
test/testbench.sv
